// ===== rtl/core/bfm_pkg.sv =====
// shared constants, codes and controller/datapath interface types of the tape machine
package bfm_pkg;

	localparam int TAPE_DEPTH = 32768;
	localparam int PROG_DEPTH = 4096;
	localparam int NEST_DEPTH = 64;

	localparam int HEAD_W  = $clog2(TAPE_DEPTH);
	localparam int PROG_AW = $clog2(PROG_DEPTH);
	localparam int PC_W    = PROG_AW + 1;
	localparam int NEST_AW = $clog2(NEST_DEPTH);
	localparam int LVL_W   = NEST_AW + 1;

	// fixed result field widths
	localparam int PC_OUT_W   = 13;
	localparam int HEAD_OUT_W = 15;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_WAIT    = 3'd1,
		ST_HALT    = 3'd2,
		ST_BRACKET = 3'd3,
		ST_FULL    = 3'd4,
		ST_NEST    = 3'd5
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    clr_wr;    // zero one tape cell of the clearing sweep
		logic    prog_wr;   // append program_char
		logic    push;      // push load position on bracket stack
		logic    pop;       // drop top of bracket stack, read issued
		logic    set_err;   // raise sticky error
		logic    cap_in;    // capture in_byte / in_valid
		logic    exec_en;   // commit one executed instruction
		logic    link_open; // match[open] <= pos
		logic    link_close;// match[pos] <= open
		logic    res_en;    // load result registers
		logic    res_exec;  // result comes from execution
		status_t res_code;  // status when not from execution
	} bfm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic len_full;
		logic ch_open;
		logic ch_close;
		logic stack_full;
		logic stack_empty;
		logic blocked;
		logic at_end;
	} bfm_sts_t;

endpackage

// ===== rtl/core/brainfuck_machine_step.sv =====
// top level of the tape machine: controller and datapath
//
// command style block: an item transfers at a rising edge with start high and busy low, and
// its result shows on the result ports for exactly one cycle with done high; the receiver
// cannot stall, so done must be taken when it comes. after reset the block is busy while
// a clearing pass writes zero to every tape cell, one cell a cycle. then a load gives its
// result in the next cycle, except a closing bracket that pairs with an open one, which
// passes through a pop state and a link state, since the bracket stack read and the two
// match table writes share single memory ports. a step that is blocked or past the program
// end is answered from idle; an executed step first does the registered reads of program,
// match table and tape at the head, then computes and writes the tape back. busy falls
// in the cycle the result shows, so the next item can transfer alongside it.
module brainfuck_machine_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic [7:0]                     program_char,
	input  logic [7:0]                     in_byte,
	input  logic                           in_valid,
	output logic                           done,
	output logic [7:0]                     out_byte,
	output logic                           out_valid,
	output logic                           in_taken,
	output logic [2:0]                     status,
	output logic [bfm_pkg::PC_OUT_W-1:0]   prog_counter,
	output logic [bfm_pkg::HEAD_OUT_W-1:0] head_pos
);

	// command and status between the two halves
	bfm_pkg::bfm_cmd_t cmd;
	bfm_pkg::bfm_sts_t sts;

	// sequencing: clearing sweep, load and step handling
	bfm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	// memories, machine registers and result registers
	bfm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.program_char (program_char),
		.in_byte      (in_byte),
		.in_valid     (in_valid),
		.done         (done),
		.out_byte     (out_byte),
		.out_valid    (out_valid),
		.in_taken     (in_taken),
		.status       (status),
		.prog_counter (prog_counter),
		.head_pos     (head_pos)
	);

endmodule

// ===== rtl/core/bfm_ctrl.sv =====
// sequencing state machine of the tape machine
module bfm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              command,
	input  bfm_pkg::bfm_sts_t sts,
	output bfm_pkg::bfm_cmd_t cmd,
	output logic              busy
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_EXEC  = 5'b00100,
		S_POP   = 5'b01000,
		S_LINK  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_code = bfm_pkg::ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start && command == bfm_pkg::CMD_LOAD) begin
					if (sts.len_full) begin
						cmd.set_err = 1'b1;
						cmd.res_en = 1'b1;
						cmd.res_code = bfm_pkg::ST_FULL;
					end else begin
						cmd.prog_wr = 1'b1;
						if (sts.ch_open && sts.stack_full) begin
							cmd.set_err = 1'b1;
							cmd.res_en = 1'b1;
							cmd.res_code = bfm_pkg::ST_NEST;
						end else if (sts.ch_open) begin
							cmd.push = 1'b1;
							cmd.res_en = 1'b1;
						end else if (sts.ch_close && sts.stack_empty) begin
							cmd.set_err = 1'b1;
							cmd.res_en = 1'b1;
							cmd.res_code = bfm_pkg::ST_BRACKET;
						end else if (sts.ch_close) begin
							cmd.pop = 1'b1;
							state_d = S_POP;
						end else begin
							cmd.res_en = 1'b1;
						end
					end
				end else if (start) begin
					if (sts.blocked) begin
						cmd.res_en = 1'b1;
						cmd.res_code = bfm_pkg::ST_BRACKET;
					end else if (sts.at_end) begin
						cmd.res_en = 1'b1;
						cmd.res_code = bfm_pkg::ST_HALT;
					end else begin
						cmd.cap_in = 1'b1;
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				cmd.exec_en = 1'b1;
				cmd.res_en = 1'b1;
				cmd.res_exec = 1'b1;
				state_d = S_IDLE;
			end
			S_POP: begin
				cmd.link_open = 1'b1;
				state_d = S_LINK;
			end
			S_LINK: begin
				cmd.link_close = 1'b1;
				cmd.res_en = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/bfm_datapath.sv =====
// program, match, stack and tape memories with machine registers and result registers
module bfm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bfm_pkg::bfm_cmd_t                   cmd,
	output bfm_pkg::bfm_sts_t                   sts,
	input  logic [7:0]                          program_char,
	input  logic [7:0]                          in_byte,
	input  logic                                in_valid,
	output logic                                done,
	output logic [7:0]                          out_byte,
	output logic                                out_valid,
	output logic                                in_taken,
	output logic [2:0]                          status,
	output logic [bfm_pkg::PC_OUT_W-1:0]        prog_counter,
	output logic [bfm_pkg::HEAD_OUT_W-1:0]      head_pos
);

	localparam logic [bfm_pkg::HEAD_W-1:0] HEAD_LAST = bfm_pkg::HEAD_W'(bfm_pkg::TAPE_DEPTH - 1);

	// memories
	logic [7:0]                  prog_mem  [bfm_pkg::PROG_DEPTH];
	logic [bfm_pkg::PROG_AW-1:0] match_mem [bfm_pkg::PROG_DEPTH];
	logic [bfm_pkg::PROG_AW-1:0] stack_mem [bfm_pkg::NEST_DEPTH];
	logic [7:0]                  tape_mem  [bfm_pkg::TAPE_DEPTH];

	logic [7:0]                  prog_rd_q;
	logic [bfm_pkg::PROG_AW-1:0] match_rd_q;
	logic [bfm_pkg::PROG_AW-1:0] stack_rd_q;
	logic [7:0]                  tape_rd_q;

	// machine registers
	logic [bfm_pkg::PC_W-1:0]    len_q;
	logic [bfm_pkg::PC_W-1:0]    ip_q;
	logic [bfm_pkg::LVL_W-1:0]   level_q;
	logic [bfm_pkg::HEAD_W-1:0]  head_q;
	logic                        err_q;
	logic [bfm_pkg::HEAD_W-1:0]  clr_q;

	logic [bfm_pkg::PROG_AW-1:0] pos_q;
	logic [bfm_pkg::PROG_AW-1:0] open_q;
	logic [7:0]                  inb_q;
	logic                        inv_q;

	// result registers
	logic                        done_q;
	logic [7:0]                  ob_q;
	logic                        ov_q;
	logic                        tk_q;
	bfm_pkg::status_t            st_q;
	logic [bfm_pkg::PC_W-1:0]    pc_q;
	logic [bfm_pkg::HEAD_W-1:0]  hp_q;

	// execute one instruction
	logic [bfm_pkg::HEAD_W-1:0]  head_nxt;
	logic [bfm_pkg::PC_W-1:0]    ip_nxt;
	logic [bfm_pkg::PC_W-1:0]    jump_pc;
	logic                        cell_wr;
	logic [7:0]                  cell_nxt;
	logic [7:0]                  ex_ob;
	logic                        ex_ov;
	logic                        ex_tk;
	bfm_pkg::status_t            ex_code;

	logic [bfm_pkg::NEST_AW-1:0] stk_raddr;
	logic [bfm_pkg::PROG_AW-1:0] match_waddr;
	logic [bfm_pkg::PROG_AW-1:0] match_wdata;
	logic [bfm_pkg::HEAD_W-1:0]  tape_waddr;
	logic [7:0]                  tape_wdata;
	logic [bfm_pkg::LVL_W-1:0]   level_dec;

	assign jump_pc   = {1'b0, match_rd_q} + bfm_pkg::PC_W'(1);
	assign level_dec = level_q - bfm_pkg::LVL_W'(1);
	assign stk_raddr = level_dec[bfm_pkg::NEST_AW-1:0];

	always_comb begin
		head_nxt = head_q;
		ip_nxt   = ip_q + bfm_pkg::PC_W'(1);
		cell_wr  = 1'b0;
		cell_nxt = tape_rd_q;
		ex_ob    = 8'd0;
		ex_ov    = 1'b0;
		ex_tk    = 1'b0;
		ex_code  = bfm_pkg::ST_OK;
		case (prog_rd_q)
			bfm_pkg::CH_RIGHT: begin
				head_nxt = (head_q == HEAD_LAST) ? '0 : head_q + bfm_pkg::HEAD_W'(1);
			end
			bfm_pkg::CH_LEFT: begin
				head_nxt = (head_q == '0) ? HEAD_LAST : head_q - bfm_pkg::HEAD_W'(1);
			end
			bfm_pkg::CH_INC: begin
				cell_wr  = 1'b1;
				cell_nxt = tape_rd_q + 8'd1;
			end
			bfm_pkg::CH_DEC: begin
				cell_wr  = 1'b1;
				cell_nxt = tape_rd_q - 8'd1;
			end
			bfm_pkg::CH_OUT: begin
				ex_ob = tape_rd_q;
				ex_ov = 1'b1;
			end
			bfm_pkg::CH_IN: begin
				if (inv_q) begin
					cell_wr  = 1'b1;
					cell_nxt = inb_q;
					ex_tk    = 1'b1;
				end else begin
					ip_nxt  = ip_q;
					ex_code = bfm_pkg::ST_WAIT;
				end
			end
			bfm_pkg::CH_OPEN: begin
				if (tape_rd_q == 8'd0) begin
					ip_nxt = jump_pc;
				end
			end
			bfm_pkg::CH_CLOSE: begin
				if (tape_rd_q != 8'd0) begin
					ip_nxt = jump_pc;
				end
			end
			default: begin
			end
		endcase
	end

	// write port selection
	always_comb begin
		if (cmd.link_open) begin
			match_waddr = stack_rd_q;
			match_wdata = pos_q;
		end else begin
			match_waddr = pos_q;
			match_wdata = open_q;
		end
		if (cmd.clr_wr) begin
			tape_waddr = clr_q;
			tape_wdata = 8'd0;
		end else begin
			tape_waddr = head_q;
			tape_wdata = cell_nxt;
		end
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (cmd.prog_wr) begin
			prog_mem[len_q[bfm_pkg::PROG_AW-1:0]] <= program_char;
		end
		prog_rd_q <= prog_mem[ip_q[bfm_pkg::PROG_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.link_open || cmd.link_close) begin
			match_mem[match_waddr] <= match_wdata;
		end
		match_rd_q <= match_mem[ip_q[bfm_pkg::PROG_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[level_q[bfm_pkg::NEST_AW-1:0]] <= len_q[bfm_pkg::PROG_AW-1:0];
		end
		stack_rd_q <= stack_mem[stk_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr || (cmd.exec_en && cell_wr)) begin
			tape_mem[tape_waddr] <= tape_wdata;
		end
		tape_rd_q <= tape_mem[head_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ip_q    <= '0;
			level_q <= '0;
			head_q  <= '0;
			err_q   <= 1'b0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.res_en;
			if (cmd.clr_wr) begin
				clr_q <= clr_q + bfm_pkg::HEAD_W'(1);
			end
			if (cmd.prog_wr) begin
				len_q <= len_q + bfm_pkg::PC_W'(1);
			end
			if (cmd.push) begin
				level_q <= level_q + bfm_pkg::LVL_W'(1);
			end else if (cmd.pop) begin
				level_q <= level_dec;
			end
			if (cmd.set_err) begin
				err_q <= 1'b1;
			end
			if (cmd.exec_en) begin
				ip_q   <= ip_nxt;
				head_q <= head_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.prog_wr) begin
			pos_q <= len_q[bfm_pkg::PROG_AW-1:0];
		end
		if (cmd.link_open) begin
			open_q <= stack_rd_q;
		end
		if (cmd.cap_in) begin
			inb_q <= in_byte;
			inv_q <= in_valid;
		end
		if (cmd.res_en) begin
			if (cmd.res_exec) begin
				ob_q <= ex_ob;
				ov_q <= ex_ov;
				tk_q <= ex_tk;
				st_q <= ex_code;
				pc_q <= ip_nxt;
				hp_q <= head_nxt;
			end else begin
				ob_q <= 8'd0;
				ov_q <= 1'b0;
				tk_q <= 1'b0;
				st_q <= cmd.res_code;
				pc_q <= ip_q;
				hp_q <= head_q;
			end
		end
	end

	assign sts.clr_last    = (clr_q == HEAD_LAST);
	assign sts.len_full    = (len_q == bfm_pkg::PC_W'(bfm_pkg::PROG_DEPTH));
	assign sts.ch_open     = (program_char == bfm_pkg::CH_OPEN);
	assign sts.ch_close    = (program_char == bfm_pkg::CH_CLOSE);
	assign sts.stack_full  = (level_q == bfm_pkg::LVL_W'(bfm_pkg::NEST_DEPTH));
	assign sts.stack_empty = (level_q == '0);
	assign sts.blocked     = err_q || (level_q != '0);
	assign sts.at_end      = (ip_q >= len_q);

	assign done         = done_q;
	assign out_byte     = ob_q;
	assign out_valid    = ov_q;
	assign in_taken     = tk_q;
	assign status       = st_q;
	assign prog_counter = bfm_pkg::PC_OUT_W'(pc_q);
	assign head_pos     = bfm_pkg::HEAD_OUT_W'(hp_q);

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= bfm_pkg::LVL_W'(bfm_pkg::NEST_DEPTH))
		else $error("bracket stack level beyond depth");
	a_ip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ip_q <= len_q)
		else $error("instruction pointer past program length");
	a_tape_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !(cmd.exec_en || cmd.res_en))
		else $error("execution during tape clearing");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench of the tape machine: directed table, random programs, error cases
`timescale 1ns / 100ps

module tb;
	import bfm_pkg::*;

	localparam real CLK_PERIOD   = 8.0;
	localparam int  RESET_CYCLES = 7;
	localparam int  MAX_REPORTS  = 10;
	// no transfer for this long means a hang; the limit sits well above the clearing pass
	// after reset, which writes all TAPE_DEPTH tape cells
	localparam int  QUIET_LIMIT  = 8 * TAPE_DEPTH;
	localparam int  TAIL_CYCLES  = 20;
	localparam int  PHASE_ITEMS  = 470;
	// random programs stop growing here, leaving room for the error sequence at the end
	localparam int  PROG_RESERVE = PROG_DEPTH - 300;

	// one result of the machine
	typedef struct packed {
		logic [7:0]            out_byte;
		logic                  out_valid;
		logic                  in_taken;
		status_t               status;
		logic [PC_OUT_W-1:0]   pc;
		logic [HEAD_OUT_W-1:0] head_at;
	} machine_res_t;

	// one row of the directed table; pinned rows carry their result typed in
	typedef struct packed {
		logic         cmd;
		logic [7:0]   ch;
		logic [7:0]   ib;
		logic         iv;
		logic         pinned;
		machine_res_t res;
	} stim_row_t;

	typedef logic [7:0] prog_bytes_t[$];

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  command;
	logic [7:0]            program_char;
	logic [7:0]            in_byte;
	logic                  in_valid;
	logic                  done;
	logic [7:0]            out_byte;
	logic                  out_valid;
	logic                  in_taken;
	logic [2:0]            status;
	logic [PC_OUT_W-1:0]   prog_counter;
	logic [HEAD_OUT_W-1:0] head_pos;

	// machine state as the testbench sees it
	logic [7:0]         prog_mem  [PROG_DEPTH];
	logic [PROG_AW-1:0] pair_pos  [PROG_DEPTH];
	logic [PROG_AW-1:0] open_stack[NEST_DEPTH];
	logic [LVL_W-1:0]   open_count;
	logic [PC_W-1:0]    prog_len;
	logic [PC_W-1:0]    ip;
	logic [7:0]         tape_mem  [TAPE_DEPTH];
	logic [HEAD_W-1:0]  head;
	logic               sticky_err;

	machine_res_t pending_results[$];
	int           mismatches   = 0;
	int           results_seen = 0;
	int           items_sent   = 0;
	int           send_gap_pct = 0;
	logic         pin_use      = 1'b0;
	machine_res_t pin_res      = '0;

	brainfuck_machine_step i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.program_char (program_char),
		.in_byte      (in_byte),
		.in_valid     (in_valid),
		.done         (done),
		.out_byte     (out_byte),
		.out_valid    (out_valid),
		.in_taken     (in_taken),
		.status       (status),
		.prog_counter (prog_counter),
		.head_pos     (head_pos)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// applies one accepted item to the machine state and returns its result
	function automatic machine_res_t advance_machine(logic cmd, logic [7:0] ch,
		logic [7:0] ib, logic iv);
		machine_res_t       r;
		logic [PC_W-1:0]    nxt;
		logic [PROG_AW-1:0] at;
		logic [PROG_AW-1:0] opener;
		logic               stalled;
		r = '0;
		r.status = ST_OK;
		stalled = 1'b0;
		if (cmd == CMD_LOAD) begin
			if (prog_len >= PROG_DEPTH) begin
				sticky_err = 1'b1;
				r.status = ST_FULL;
			end else begin
				at = prog_len[PROG_AW-1:0];
				prog_mem[at] = ch;
				if (ch == CH_OPEN) begin
					if (open_count >= NEST_DEPTH) begin
						// stored but never paired
						sticky_err = 1'b1;
						r.status = ST_NEST;
					end else begin
						open_stack[open_count[NEST_AW-1:0]] = at;
						open_count = open_count + 1'b1;
					end
				end else if (ch == CH_CLOSE) begin
					if (open_count == 0) begin
						sticky_err = 1'b1;
						r.status = ST_BRACKET;
					end else begin
						open_count = open_count - 1'b1;
						opener = open_stack[open_count[NEST_AW-1:0]];
						pair_pos[opener] = at;
						pair_pos[at] = opener;
					end
				end
				prog_len = prog_len + 1'b1;
			end
		end else if (sticky_err || open_count != 0) begin
			// refused while in error or while a loop is still open
			r.status = ST_BRACKET;
		end else if (ip >= prog_len) begin
			r.status = ST_HALT;
		end else begin
			at = ip[PROG_AW-1:0];
			nxt = ip + 1'b1;
			case (prog_mem[at])
				CH_RIGHT: head = (int'(head) + 1 >= TAPE_DEPTH) ? '0 : head + 1'b1;
				CH_LEFT:  head = (head == 0) ? HEAD_W'(TAPE_DEPTH - 1) : head - 1'b1;
				CH_INC:   tape_mem[head] = tape_mem[head] + 8'd1;
				CH_DEC:   tape_mem[head] = tape_mem[head] - 8'd1;
				CH_OUT: begin
					r.out_byte = tape_mem[head];
					r.out_valid = 1'b1;
				end
				CH_IN: begin
					if (!iv) begin
						// nothing moves until a byte is offered
						stalled = 1'b1;
						r.status = ST_WAIT;
					end else begin
						tape_mem[head] = ib;
						r.in_taken = 1'b1;
					end
				end
				CH_OPEN:  if (tape_mem[head] == 0) nxt = {1'b0, pair_pos[at]} + 1'b1;
				CH_CLOSE: if (tape_mem[head] != 0) nxt = {1'b0, pair_pos[at]} + 1'b1;
				default: ;
			endcase
			if (!stalled)
				ip = nxt;
		end
		r.pc = ip;
		r.head_at = head;
		return r;
	endfunction

	// result check and prediction, both on the rising edge
	always @(posedge clk) begin : monitor
		machine_res_t want;
		machine_res_t model;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: result %0d arrived with nothing outstanding",
							$time, results_seen);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (out_byte !== want.out_byte || out_valid !== want.out_valid ||
						in_taken !== want.in_taken || status !== want.status ||
						prog_counter !== want.pc || head_pos !== want.head_at) begin
						if (mismatches < MAX_REPORTS) begin
							$display("%0t: mismatch on result %0d", $time, results_seen);
							$display("  expected byte %02h ov %0b taken %0b st %0d pc %0d head %0d",
								want.out_byte, want.out_valid, want.in_taken, want.status,
								want.pc, want.head_at);
							$display("  actual   byte %02h ov %0b taken %0b st %0d pc %0d head %0d",
								out_byte, out_valid, in_taken, status, prog_counter, head_pos);
						end
						mismatches++;
					end
				end
			end
			// an item transfers alongside the previous result, so it is queued after the check
			if (start && !busy) begin
				model = advance_machine(command, program_char, in_byte, in_valid);
				pending_results.push_back(pin_use ? pin_res : model);
			end
		end
	end

	// ends the run when nothing has transferred for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	// drives one item from a falling edge and returns at the falling edge after its transfer
	task automatic transfer_item(logic cmd, logic [7:0] ch, logic [7:0] ib, logic iv,
		logic pinned, machine_res_t res);
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		command      <= cmd;
		program_char <= ch;
		in_byte      <= ib;
		in_valid     <= iv;
		pin_use = pinned;
		pin_res = res;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic append_char(logic [7:0] ch);
		transfer_item(CMD_LOAD, ch, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
	endtask

	// zero input bytes are frequent so that loops closed by a read come to an end
	task automatic random_step();
		transfer_item(CMD_STEP, 8'($urandom_range(255)),
			$urandom_range(1) ? 8'h00 : 8'($urandom_range(255)),
			$urandom_range(99) < 85, 1'b0, '0);
	endtask

	// random balanced code; every loop ends on a read right before its close
	function automatic prog_bytes_t build_code(int depth);
		prog_bytes_t code;
		logic [7:0]  ch;
		repeat ($urandom_range(6, 1)) begin
			case ($urandom_range(9))
				0: code.push_back(CH_RIGHT);
				1: code.push_back(CH_LEFT);
				2: code.push_back(CH_INC);
				3: code.push_back(CH_DEC);
				4: code.push_back(CH_OUT);
				5: code.push_back(CH_IN);
				6: begin
					do ch = 8'($urandom_range(255));
					while (ch == CH_OPEN || ch == CH_CLOSE);
					code.push_back(ch);
				end
				default: if (depth < 3) begin
					code.push_back(CH_OPEN);
					code = {code, build_code(depth + 1)};
					code.push_back(CH_IN);
					code.push_back(CH_CLOSE);
				end else begin
					code.push_back(CH_INC);
				end
			endcase
		end
		return code;
	endfunction

	// load a piece of code, with the odd step in between, then run it
	task automatic run_snippet();
		prog_bytes_t code;
		int          budget;
		code = build_code(0);
		foreach (code[k]) begin
			append_char(code[k]);
			// refused while a loop is open, otherwise runs code loaded so far
			if ($urandom_range(9) == 0)
				random_step();
		end
		budget = 4 * code.size() + 8;
		while (ip < prog_len && budget > 0) begin
			random_step();
			budget--;
		end
		// a few more steps past the end of the program
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(3, 1)) random_step();
	endtask

	function automatic stim_row_t row_of(logic cmd, logic [7:0] ch, logic [7:0] ib, logic iv);
		stim_row_t r;
		r = '0;
		r.cmd = cmd;
		r.ch  = ch;
		r.ib  = ib;
		r.iv  = iv;
		return r;
	endfunction

	function automatic stim_row_t pinned_row(stim_row_t r, logic [7:0] ob, logic ov, logic tk,
		status_t st, int pc, int hd);
		r.pinned            = 1'b1;
		r.res.out_byte      = ob;
		r.res.out_valid     = ov;
		r.res.in_taken      = tk;
		r.res.status        = st;
		r.res.pc            = PC_OUT_W'(pc);
		r.res.head_at       = HEAD_OUT_W'(hd);
		return r;
	endfunction

	initial begin : stimulus
		stim_row_t rows[$];
		int        phase_start;
		int        drain;

		arst_n       = 1'b0;
		start        = 1'b0;
		command      = CMD_LOAD;
		program_char = 8'h00;
		in_byte      = 8'h00;
		in_valid     = 1'b0;
		open_count   = '0;
		prog_len     = '0;
		ip           = '0;
		head         = '0;
		sticky_err   = 1'b0;
		foreach (tape_mem[k])
			tape_mem[k] = 8'h00;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table: program ", . + - < > [ , ] [ ]" grown one byte at a time
		rows.push_back(pinned_row(row_of(CMD_STEP, 8'h00, 8'h00, 1'b0),
			8'h00, 1'b0, 1'b0, ST_HALT, 0, 0));               // empty program
		rows.push_back(row_of(CMD_LOAD, CH_IN, 8'h00, 1'b0));
		rows.push_back(pinned_row(row_of(CMD_STEP, 8'hFF, 8'hAA, 1'b0),
			8'h00, 1'b0, 1'b0, ST_WAIT, 0, 0));               // read with no byte offered
		rows.push_back(pinned_row(row_of(CMD_STEP, 8'h00, 8'hFF, 1'b1),
			8'h00, 1'b0, 1'b1, ST_OK, 1, 0));                 // read takes the top byte
		rows.push_back(row_of(CMD_LOAD, CH_OUT, 8'h55, 1'b1));
		rows.push_back(pinned_row(row_of(CMD_STEP, 8'h00, 8'h00, 1'b1),
			8'hFF, 1'b1, 1'b0, ST_OK, 2, 0));                 // emits it
		rows.push_back(row_of(CMD_LOAD, CH_INC, 8'h00, 1'b0));
		rows.push_back(row_of(CMD_STEP, 8'h00, 8'h00, 1'b1)); // cell wraps up to zero
		rows.push_back(row_of(CMD_LOAD, CH_DEC, 8'h00, 1'b0));
		rows.push_back(row_of(CMD_STEP, 8'h00, 8'h00, 1'b1)); // and back down
		rows.push_back(row_of(CMD_LOAD, CH_LEFT, 8'h00, 1'b0));
		rows.push_back(pinned_row(row_of(CMD_STEP, 8'h00, 8'h00, 1'b0),
			8'h00, 1'b0, 1'b0, ST_OK, 5, TAPE_DEPTH - 1));    // head wraps below zero
		rows.push_back(row_of(CMD_LOAD, CH_RIGHT, 8'h00, 1'b0));
		rows.push_back(pinned_row(row_of(CMD_STEP, 8'h00, 8'h00, 1'b0),
			8'h00, 1'b0, 1'b0, ST_OK, 6, 0));                 // and past the top
		rows.push_back(row_of(CMD_LOAD, CH_OPEN, 8'h00, 1'b0));
		rows.push_back(pinned_row(row_of(CMD_STEP, 8'h00, 8'h00, 1'b1),
			8'h00, 1'b0, 1'b0, ST_BRACKET, 6, 0));            // loop still open
		rows.push_back(row_of(CMD_LOAD, CH_IN, 8'h00, 1'b0));
		rows.push_back(row_of(CMD_LOAD, CH_CLOSE, 8'h00, 1'b0));
		rows.push_back(row_of(CMD_STEP, 8'h00, 8'h33, 1'b1)); // enters, cell nonzero
		rows.push_back(row_of(CMD_STEP, 8'h00, 8'h01, 1'b1));
		rows.push_back(row_of(CMD_STEP, 8'h00, 8'h33, 1'b1)); // jumps back
		rows.push_back(row_of(CMD_STEP, 8'h00, 8'h00, 1'b1));
		rows.push_back(row_of(CMD_STEP, 8'h00, 8'h33, 1'b1)); // leaves the loop
		rows.push_back(pinned_row(row_of(CMD_STEP, 8'h00, 8'h00, 1'b0),
			8'h00, 1'b0, 1'b0, ST_HALT, 9, 0));
		rows.push_back(row_of(CMD_LOAD, CH_OPEN, 8'h00, 1'b0));  // loaded during execution
		rows.push_back(row_of(CMD_LOAD, CH_CLOSE, 8'h00, 1'b0));
		rows.push_back(row_of(CMD_STEP, 8'h00, 8'h00, 1'b1)); // skips, cell zero

		send_gap_pct = 35;
		foreach (rows[k])
			transfer_item(rows[k].cmd, rows[k].ch, rows[k].ib, rows[k].iv,
				rows[k].pinned, rows[k].res);

		// random programs: sender gaps often, then very often, then never
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 35 : (phase == 1) ? 87 : 0;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS && prog_len < PROG_RESERVE)
				run_snippet();
		end

		// error cases last: the error is sticky and only reset clears it
		drain = 0;
		while (ip < prog_len && drain < 300) begin
			random_step();
			drain++;
		end
		append_char(CH_CLOSE);                        // close with no loop open
		repeat (3) random_step();                     // refused from here on
		repeat (NEST_DEPTH + 2) append_char(CH_OPEN); // nesting one too deep, then more
		random_step();
		while (prog_len < PROG_DEPTH) begin
			if ($urandom_range(9) == 0)
				random_step();
			else
				append_char(8'($urandom_range(255)));
		end
		repeat (3) append_char(8'($urandom_range(255))); // program store full
		random_step();

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
